// ===== rtl/gecu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gecu_pkg;

  // default grid side limit and the fixed field widths
  localparam int MAX_SIDE_DEF = 64;
  localparam int CFG_W        = 7;
  localparam int IDX_W        = 12;
  localparam int VAL_W        = 16;
  localparam int POS_W        = 6;
  localparam int NBR_N        = 9;

  localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;

  // configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] cell_index;
    logic [VAL_W-1:0] cell_value;
    logic [VAL_W-1:0] new_nw;
    logic [VAL_W-1:0] new_n;
    logic [VAL_W-1:0] new_ne;
    logic [VAL_W-1:0] new_w;
    logic [VAL_W-1:0] new_center;
    logic [VAL_W-1:0] new_e;
    logic [VAL_W-1:0] new_sw;
    logic [VAL_W-1:0] new_s;
    logic [VAL_W-1:0] new_se;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] top_col;
    logic [POS_W-1:0] top_row;
    logic [VAL_W-1:0] top_level;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_wr;
    logic step_start;
    logic scan_rd;
    logic nbr_wr;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic nbr_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/gecu_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gecu_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/gecu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gecu_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  input  wire                     in_opcode_i,
  output logic                    in_ready_o,
  input  gecu_pkg::dp_status_t    status_i,
  output gecu_pkg::dp_cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_NBR   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode_i == gecu_pkg::OP_STEP) begin
            cmd_o.step_start = 1'b1;
            state_d          = ST_SCAN;
          end else begin
            cmd_o.load_wr = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last compare settles
      ST_DRAIN: begin
        state_d = ST_NBR;
      end
      ST_NBR: begin
        cmd_o.nbr_wr = 1'b1;
        if (status_i.nbr_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gecu_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gecu_dp #(
  parameter int MAX_SIDE = gecu_pkg::MAX_SIDE_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire                              cfg_idx_i,
  input  wire  [gecu_pkg::CFG_W-1:0]       cfg_data_i,
  input  gecu_pkg::in_item_t               in_data_i,
  input  gecu_pkg::dp_cmd_t                cmd_i,
  output gecu_pkg::dp_status_t             status_o,
  input  wire                              out_ready_i,
  output logic                             out_valid_o,
  output gecu_pkg::out_item_t              out_data_o
);

  localparam int SW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int EW    = $clog2(MAX_SIDE + 1);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = 2 * SW;
  localparam int VW    = gecu_pkg::VAL_W;
  localparam int NN    = gecu_pkg::NBR_N;

  // configuration
  logic [gecu_pkg::CFG_W-1:0] cfg_w_q, cfg_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= gecu_pkg::SIDE_RESET;
      cfg_h_q <= gecu_pkg::SIDE_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gecu_pkg::CFG_GRID_WIDTH) begin
        cfg_w_q <= cfg_data_i;
      end else begin
        cfg_w_q <= cfg_w_q;
        cfg_h_q <= cfg_data_i;
      end
    end
  end

  // zero acts as one, above the limit acts as the limit
  function automatic logic [EW-1:0] eff_side(input logic [gecu_pkg::CFG_W-1:0] r);
    logic [31:0] r32;
    r32 = 32'(r);
    if (r32 == 32'd0) begin
      return EW'(1);
    end else if (r32 > 32'(MAX_SIDE)) begin
      return EW'(MAX_SIDE);
    end else begin
      return EW'(r32);
    end
  endfunction

  logic [EW-1:0] w_q, h_q;
  logic [AW-1:0] pos_q;
  logic [SW-1:0] col_q, row_q;
  logic          cmp_vld_q;
  logic [SW-1:0] cmp_col_q, cmp_row_q;
  logic [AW-1:0] cmp_pos_q;
  logic [VW-1:0] rdata_q;
  logic [VW-1:0] best_q;
  logic [SW-1:0] best_col_q, best_row_q;
  logic [AW-1:0] best_pos_q;
  logic [VW-1:0] repl_q [NN];
  logic [1:0]    dy_q, dx_q;
  logic          out_vld_q;
  gecu_pkg::out_item_t out_q;

  logic          col_end, row_end;
  logic          row_ok, col_ok;
  logic [AW-1:0] w_ext, nbr_addr, row_addr;
  logic          load_ok;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [VW-1:0] mem_wdata;

  assign col_end = (EW'(col_q) == (w_q - EW'(1)));
  assign row_end = (EW'(row_q) == (h_q - EW'(1)));

  assign status_o.scan_last = col_end && row_end;
  assign status_o.nbr_last  = (dy_q == 2'd2) && (dx_q == 2'd2);
  assign status_o.out_free  = !out_vld_q || out_ready_i;

  // scan counters, raster order
  always_ff @(posedge clk_i) begin
    if (cmd_i.step_start) begin
      w_q   <= eff_side(cfg_w_q);
      h_q   <= eff_side(cfg_h_q);
      pos_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.scan_rd) begin
      pos_q <= pos_q + AW'(1);
      if (col_end) begin
        col_q <= '0;
        row_q <= row_q + SW'(1);
      end else begin
        col_q <= col_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_col_q <= col_q;
    cmp_row_q <= row_q;
    cmp_pos_q <= pos_q;
  end

  // running maximum, later cell wins a tie
  always_ff @(posedge clk_i) begin
    if (cmd_i.step_start) begin
      best_q     <= '0;
      best_col_q <= '0;
      best_row_q <= '0;
      best_pos_q <= '0;
    end else if (cmp_vld_q && (rdata_q >= best_q)) begin
      best_q     <= rdata_q;
      best_col_q <= cmp_col_q;
      best_row_q <= cmp_row_q;
      best_pos_q <= cmp_pos_q;
    end
  end

  // replacement values shift out one per neighbor slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.step_start) begin
      repl_q[0] <= in_data_i.new_nw;
      repl_q[1] <= in_data_i.new_n;
      repl_q[2] <= in_data_i.new_ne;
      repl_q[3] <= in_data_i.new_w;
      repl_q[4] <= in_data_i.new_center;
      repl_q[5] <= in_data_i.new_e;
      repl_q[6] <= in_data_i.new_sw;
      repl_q[7] <= in_data_i.new_s;
      repl_q[8] <= in_data_i.new_se;
    end else if (cmd_i.nbr_wr) begin
      for (int i = 0; i < NN - 1; i++) begin
        repl_q[i] <= repl_q[i+1];
      end
      repl_q[NN-1] <= repl_q[NN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_start) begin
      dy_q <= 2'd0;
      dx_q <= 2'd0;
    end else if (cmd_i.nbr_wr) begin
      if (dx_q == 2'd2) begin
        dx_q <= 2'd0;
        dy_q <= dy_q + 2'd1;
      end else begin
        dx_q <= dx_q + 2'd1;
      end
    end
  end

  // neighbor address, wraps cancel for cells inside the grid
  assign w_ext  = AW'(w_q);
  assign row_ok = !((dy_q == 2'd0) && (best_row_q == '0)) &&
                  !((dy_q == 2'd2) && (EW'(best_row_q) == (h_q - EW'(1))));
  assign col_ok = !((dx_q == 2'd0) && (best_col_q == '0)) &&
                  !((dx_q == 2'd2) && (EW'(best_col_q) == (w_q - EW'(1))));

  always_comb begin
    unique case (dy_q)
      2'd0:    row_addr = best_pos_q - w_ext;
      2'd2:    row_addr = best_pos_q + w_ext;
      default: row_addr = best_pos_q;
    endcase
    unique case (dx_q)
      2'd0:    nbr_addr = row_addr - AW'(1);
      2'd2:    nbr_addr = row_addr + AW'(1);
      default: nbr_addr = row_addr;
    endcase
  end

  assign load_ok = (32'(in_data_i.cell_index) < 32'(DEPTH));

  always_comb begin
    if (cmd_i.nbr_wr) begin
      mem_we    = row_ok && col_ok;
      mem_waddr = nbr_addr;
      mem_wdata = repl_q[0];
    end else begin
      mem_we    = cmd_i.load_wr && load_ok;
      mem_waddr = AW'(in_data_i.cell_index);
      mem_wdata = in_data_i.cell_value;
    end
  end

  // cell store
  logic [VW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[pos_q];
  end

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.top_col   <= gecu_pkg::POS_W'(best_col_q);
      out_q.top_row   <= gecu_pkg::POS_W'(best_row_q);
      out_q.top_level <= best_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/grid_extremal_cell_update_top.sv =====
// load word: written to the store at the edge that accepts it, no result
// step word: scan of W*H cells at one read a cycle, a drain state, nine neighbor
//   write slots, then the result is loaded once the result register is free
// one word in flight at a time; the next word is taken while a result waits
// reset clears control and the size registers (64x64); the cell store is not
//   cleared and holds garbage until loaded
`timescale 1ns / 1ps
`default_nettype none

module grid_extremal_cell_update_top #(
  parameter int MAX_SIDE = gecu_pkg::MAX_SIDE_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // size registers
  input  wire                         cfg_we_i,
  input  wire                         cfg_idx_i,
  input  wire [gecu_pkg::CFG_W-1:0]   cfg_data_i,
  // word channels
  gecu_chan_if.sink                   in_i,
  gecu_chan_if.source                 out_o
);

  gecu_pkg::dp_cmd_t    cmd;
  gecu_pkg::dp_status_t status;
  gecu_pkg::in_item_t   in_data;
  gecu_pkg::out_item_t  out_data;

  assign in_data    = in_i.data;
  assign out_o.data = out_data;

  // sequencer: idle / scan / drain / neighbor writes / result hand-off
  gecu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_data.opcode),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // store, scan counters, running maximum and result register
  gecu_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_data)
  );

endmodule

`default_nettype wire
